// ===== rtl/core/alarm_tone_sequencer_unit_defines.svh =====
// Assertion macros for the alarm tone sequencer.
// Each expects clk and rst_n in scope; checks are off while reset is held.
`ifndef ALARM_TONE_SEQUENCER_UNIT_DEFINES_SVH
`define ALARM_TONE_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication
`define ATS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alarm tone sequencer check failed");

// Next-cycle implication
`define ATS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alarm tone sequencer check failed");

`endif

// ===== rtl/core/ats_pkg.sv =====
`default_nettype none
package ats_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_EXPIRE = 2'd2,
    KIND_HEARD  = 2'd3
  } kind_t;

  // Alarm levels
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_LOW  = 2'd1;
  localparam logic [1:0] LVL_MED  = 2'd2;
  localparam logic [1:0] LVL_HIGH = 2'd3;

  // Pattern lengths
  localparam logic [4:0] LEN_LOW  = 5'd19;
  localparam logic [4:0] LEN_MED  = 5'd13;
  localparam logic [4:0] LEN_HIGH = 5'd23;

  // Tone periods, zero means silence
  localparam logic [7:0] NOTE_NONE = 8'h00;
  localparam logic [7:0] NOTE_A    = 8'h8D;
  localparam logic [7:0] NOTE_C    = 8'hEE;
  localparam logic [7:0] NOTE_E    = 8'hBD;
  localparam logic [7:0] NOTE_F    = 8'hB2;
  localparam logic [7:0] NOTE_UNUSED = 8'h80;

  // Register indexes
  localparam logic [2:0] REG_DUR_LONG   = 3'd0;
  localparam logic [2:0] REG_DUR_400    = 3'd1;
  localparam logic [2:0] REG_DUR_200    = 3'd2;
  localparam logic [2:0] REG_DUR_180    = 3'd3;
  localparam logic [2:0] REG_DUR_100    = 3'd4;
  localparam logic [2:0] REG_MISS_LIMIT = 3'd5;

  // Duration selectors
  typedef enum logic [2:0] {
    DUR_LONG = 3'd0,
    DUR_400  = 3'd1,
    DUR_200  = 3'd2,
    DUR_180  = 3'd3,
    DUR_100  = 3'd4
  } dur_sel_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] alarm_level;
  } in_item_t;

  typedef struct packed {
    logic       tone_on;
    logic [7:0] tone_period;
    logic [7:0] timer_load;
    logic       timer_running;
    logic       fail_raise;
    logic       fail_clear;
    logic [4:0] step_index;
  } out_item_t;

  // Configuration register contents
  typedef struct packed {
    logic [7:0] dur_long;
    logic [7:0] dur_400;
    logic [7:0] dur_200;
    logic [7:0] dur_180;
    logic [7:0] dur_100;
    logic [1:0] miss_limit;
  } cfg_regs_t;

  // One pattern step
  typedef struct packed {
    logic [7:0] note;
    dur_sel_t   dur;
  } slot_t;

  // Step lookup result handed to the sequencer
  typedef struct packed {
    logic       active;
    logic       in_range;
    slot_t      slot;
    logic [4:0] step_next;
  } step_info_t;

  function automatic logic [4:0] pattern_len(input logic [1:0] lvl);
    logic [4:0] len;
    unique case (lvl)
      LVL_LOW:  len = LEN_LOW;
      LVL_MED:  len = LEN_MED;
      LVL_HIGH: len = LEN_HIGH;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

  // Fixed tone patterns; steps past a pattern's end read as a long silence
  function automatic slot_t pattern_slot(input logic [1:0] lvl, input logic [4:0] stp);
    slot_t s;
    s = '{note: NOTE_NONE, dur: DUR_LONG};
    unique case (lvl)
      LVL_LOW: begin
        unique case (stp)
          5'd0:    s = '{note: NOTE_E, dur: DUR_200};
          5'd1:    s = '{note: NOTE_NONE, dur: DUR_200};
          5'd2:    s = '{note: NOTE_C, dur: DUR_200};
          default: s = '{note: NOTE_NONE, dur: DUR_LONG};
        endcase
      end
      LVL_MED: begin
        unique case (stp)
          5'd0:       s = '{note: NOTE_C, dur: DUR_200};
          5'd1, 5'd3: s = '{note: NOTE_NONE, dur: DUR_200};
          5'd2:       s = '{note: NOTE_A, dur: DUR_200};
          5'd4:       s = '{note: NOTE_F, dur: DUR_200};
          default:    s = '{note: NOTE_NONE, dur: DUR_LONG};
        endcase
      end
      LVL_HIGH: begin
        unique case (stp)
          5'd0, 5'd10:  s = '{note: NOTE_C, dur: DUR_180};
          5'd2, 5'd6, 5'd12, 5'd16:
                        s = '{note: NOTE_A, dur: DUR_180};
          5'd4, 5'd8, 5'd14, 5'd18:
                        s = '{note: NOTE_F, dur: DUR_180};
          5'd1, 5'd3, 5'd7, 5'd11, 5'd13, 5'd17:
                        s = '{note: NOTE_NONE, dur: DUR_100};
          5'd5, 5'd15:  s = '{note: NOTE_NONE, dur: DUR_400};
          default:      s = '{note: NOTE_NONE, dur: DUR_LONG};
        endcase
      end
      default: s = '{note: NOTE_NONE, dur: DUR_LONG};
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ats_regs.sv =====
`default_nettype none
module ats_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output ats_pkg::cfg_regs_t     cfg
);

  ats_pkg::cfg_regs_t cfg_r;
  logic [2:0]         idx;
  logic               wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  // Register writes on the access phase of a write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dur_long   <= 8'd255;
      cfg_r.dur_400    <= 8'd102;
      cfg_r.dur_200    <= 8'd51;
      cfg_r.dur_180    <= 8'd46;
      cfg_r.dur_100    <= 8'd26;
      cfg_r.miss_limit <= 2'd2;
    end else if (wr_en) begin
      unique case (idx)
        ats_pkg::REG_DUR_LONG:   cfg_r.dur_long   <= pwdata[7:0];
        ats_pkg::REG_DUR_400:    cfg_r.dur_400    <= pwdata[7:0];
        ats_pkg::REG_DUR_200:    cfg_r.dur_200    <= pwdata[7:0];
        ats_pkg::REG_DUR_180:    cfg_r.dur_180    <= pwdata[7:0];
        ats_pkg::REG_DUR_100:    cfg_r.dur_100    <= pwdata[7:0];
        ats_pkg::REG_MISS_LIMIT: cfg_r.miss_limit <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      ats_pkg::REG_DUR_LONG:   prdata = {24'd0, cfg_r.dur_long};
      ats_pkg::REG_DUR_400:    prdata = {24'd0, cfg_r.dur_400};
      ats_pkg::REG_DUR_200:    prdata = {24'd0, cfg_r.dur_200};
      ats_pkg::REG_DUR_180:    prdata = {24'd0, cfg_r.dur_180};
      ats_pkg::REG_DUR_100:    prdata = {24'd0, cfg_r.dur_100};
      ats_pkg::REG_MISS_LIMIT: prdata = {30'd0, cfg_r.miss_limit};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/ats_pattern.sv =====
`default_nettype none
module ats_pattern (
  input  wire logic [1:0]        level,
  input  wire logic [4:0]        step,
  output ats_pkg::step_info_t    info
);

  logic [4:0] len;
  logic [5:0] step_inc;

  assign len      = ats_pkg::pattern_len(level);
  assign step_inc = {1'b0, step} + 6'd1;

  // Look up the step and work out the following one, wrapping at pattern end
  always_comb begin
    info.active   = (level != ats_pkg::LVL_NONE);
    info.in_range = (step < len);
    info.slot     = ats_pkg::pattern_slot(level, step);
    if (!info.in_range || (step_inc >= {1'b0, len})) begin
      info.step_next = 5'd0;
    end else begin
      info.step_next = step_inc[4:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/alarm_tone_sequencer_unit.sv =====
// Alarm tone sequencer: every accepted item (set level, clear, timer expired,
// tone heard) yields exactly one result, registered on its transfer.
// One item is taken per clock: the whole state update is a single
// combinational pass from the item and the held state into the output
// register, and a new item is taken whenever that register is empty or its
// result is being taken in the same cycle. Durations and the miss limit come
// from the register port and should only be written while no item is pending.
`default_nettype none
module alarm_tone_sequencer_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ats_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ats_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

`include "alarm_tone_sequencer_unit_defines.svh"

  ats_pkg::cfg_regs_t  cfg;
  ats_pkg::step_info_t info;
  ats_pkg::kind_t      kind;

  // Sequencer state
  logic [1:0] level_r, level_nxt;
  logic [4:0] step_r, step_nxt;
  logic       sounding_r, sounding_nxt;
  logic       heard_r, heard_nxt;
  logic [1:0] misses_r, misses_nxt;
  logic [7:0] tone_r, tone_nxt;

  // Output register
  logic               out_valid_r;
  ats_pkg::out_item_t out_data_r, out_data_nxt;

  logic       in_xfer;
  logic       run;
  logic [1:0] look_level;
  logic [4:0] look_step;
  logic [7:0] dur_val;

  ats_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // A set restarts the new level at step 0
  assign kind       = ats_pkg::kind_t'(in_data.kind);
  assign look_level = (kind == ats_pkg::KIND_SET) ? in_data.alarm_level : level_r;
  assign look_step  = (kind == ats_pkg::KIND_SET) ? 5'd0 : step_r;

  ats_pattern u_pattern (
    .level (look_level),
    .step  (look_step),
    .info  (info)
  );

  assign pready    = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Duration select
  always_comb begin
    unique case (info.slot.dur)
      ats_pkg::DUR_LONG: dur_val = cfg.dur_long;
      ats_pkg::DUR_400:  dur_val = cfg.dur_400;
      ats_pkg::DUR_200:  dur_val = cfg.dur_200;
      ats_pkg::DUR_180:  dur_val = cfg.dur_180;
      ats_pkg::DUR_100:  dur_val = cfg.dur_100;
      default:           dur_val = cfg.dur_200;
    endcase
  end

  // Single-pass item processing
  always_comb begin
    level_nxt    = level_r;
    step_nxt     = step_r;
    sounding_nxt = sounding_r;
    heard_nxt    = heard_r;
    misses_nxt   = misses_r;
    tone_nxt     = tone_r;
    run          = 1'b0;
    out_data_nxt = '0;

    unique case (kind)
      ats_pkg::KIND_SET: begin
        level_nxt = in_data.alarm_level;
        step_nxt  = 5'd0;
        run       = 1'b1;
      end
      ats_pkg::KIND_CLEAR: begin
        level_nxt    = ats_pkg::LVL_NONE;
        sounding_nxt = 1'b0;
      end
      ats_pkg::KIND_EXPIRE: begin
        run = 1'b1;
        // Check the tone that just ended
        if (sounding_r) begin
          if (heard_r) begin
            out_data_nxt.fail_clear = 1'b1;
            misses_nxt              = 2'd0;
          end else if (misses_r >= cfg.miss_limit) begin
            out_data_nxt.fail_raise = 1'b1;
          end else begin
            misses_nxt = misses_r + 2'd1;
          end
        end
      end
      ats_pkg::KIND_HEARD: begin
        if (sounding_r) begin
          heard_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    // Run the selected step
    if (run) begin
      sounding_nxt = 1'b0;
      if (info.active) begin
        out_data_nxt.timer_running = 1'b1;
        step_nxt                   = info.step_next;
        if (!info.in_range) begin
          out_data_nxt.timer_load = cfg.dur_200;
        end else begin
          out_data_nxt.timer_load = dur_val;
          if (info.slot.note != ats_pkg::NOTE_NONE) begin
            tone_nxt     = info.slot.note;
            sounding_nxt = 1'b1;
            heard_nxt    = 1'b0;
          end
        end
      end
    end

    out_data_nxt.tone_on     = sounding_nxt;
    out_data_nxt.tone_period = tone_nxt;
    out_data_nxt.step_index  = step_nxt;
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= ats_pkg::LVL_NONE;
      step_r      <= 5'd0;
      sounding_r  <= 1'b0;
      heard_r     <= 1'b1;
      misses_r    <= 2'd0;
      tone_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        level_r    <= level_nxt;
        step_r     <= step_nxt;
        sounding_r <= sounding_nxt;
        heard_r    <= heard_nxt;
        misses_r   <= misses_nxt;
        tone_r     <= tone_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  `ATS_ASSERT_IMP(a_pulse_excl, out_valid_r, !(out_data_r.fail_raise && out_data_r.fail_clear))
  `ATS_ASSERT_IMP(a_idle_load, out_valid_r && !out_data_r.timer_running,
                  out_data_r.timer_load == 8'd0)
  `ATS_ASSERT_IMP(a_tone_period, out_valid_r && out_data_r.tone_on,
                  out_data_r.tone_period != ats_pkg::NOTE_NONE)
  `ATS_ASSERT_IMP(a_step_range, 1'b1, step_r < ats_pkg::LEN_HIGH)
  `ATS_ASSERT_NXT(a_xfer_result, in_xfer, out_valid_r && (out_data_r.step_index == step_r))

endmodule
`default_nettype wire

// ===== tb/alarm_tone_sequencer_unit_tb.sv =====
`default_nettype none
module alarm_tone_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ats_pkg::*;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // Block ports
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alarm_tone_sequencer_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Stimulus and expectation stores
  in_item_t  stim_items [$];
  out_item_t tone_results_due [$];
  int        errors = 0;

  // Mirror of the duration registers and the miss limit
  logic [7:0] dur_regs [0:4];
  logic [1:0] miss_cap;

  // Mirror of the sequencer state
  logic [1:0] cur_level;
  logic [4:0] cur_step;
  logic       tone_live;
  logic       tone_heard;
  logic [1:0] miss_count;
  logic [7:0] held_period;

  // Idle shaping
  bit idle_on = 1'b1;
  int quiet_left = 0;

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Play the step at cur_step of the current level; returns 1 when a timer starts
  function automatic logic run_pattern_step(output logic [7:0] load);
    logic [4:0] len;
    logic [7:0] note;
    dur_sel_t   dsel;
    tone_live = 1'b0;
    load = 8'h00;
    note = NOTE_NONE;
    dsel = DUR_LONG;
    case (cur_level)
      LVL_LOW: begin
        len = LEN_LOW;
        case (cur_step)
          5'd0: begin note = NOTE_E; dsel = DUR_200; end
          5'd1: dsel = DUR_200;
          5'd2: begin note = NOTE_C; dsel = DUR_200; end
          default: ;
        endcase
      end
      LVL_MED: begin
        len = LEN_MED;
        case (cur_step)
          5'd0: begin note = NOTE_C; dsel = DUR_200; end
          5'd1, 5'd3: dsel = DUR_200;
          5'd2: begin note = NOTE_A; dsel = DUR_200; end
          5'd4: begin note = NOTE_F; dsel = DUR_200; end
          default: ;
        endcase
      end
      LVL_HIGH: begin
        len = LEN_HIGH;
        case (cur_step)
          5'd0, 5'd10: begin note = NOTE_C; dsel = DUR_180; end
          5'd2, 5'd6, 5'd12, 5'd16: begin note = NOTE_A; dsel = DUR_180; end
          5'd4, 5'd8, 5'd14, 5'd18: begin note = NOTE_F; dsel = DUR_180; end
          5'd1, 5'd3, 5'd7, 5'd11, 5'd13, 5'd17: dsel = DUR_100;
          5'd5, 5'd15: dsel = DUR_400;
          default: ;
        endcase
      end
      default: return 1'b0;
    endcase
    // step past the end of the pattern: short silence, back to the start
    if (cur_step >= len) begin
      cur_step = 5'd0;
      load = dur_regs[DUR_200];
      return 1'b1;
    end
    if (note != NOTE_NONE) begin
      held_period = note;
      tone_live = 1'b1;
      tone_heard = 1'b0;
    end
    cur_step = cur_step + 5'd1;
    if (cur_step >= len) cur_step = 5'd0;
    load = dur_regs[dsel];
    return 1'b1;
  endfunction

  // Expected result of one transfer on the input channel
  function automatic out_item_t predict_tone_result(input in_item_t item);
    out_item_t  r;
    logic [7:0] load;
    logic       started;
    r = '0;
    load = 8'h00;
    started = 1'b0;
    case (kind_t'(item.kind))
      KIND_SET: begin
        cur_level = item.alarm_level;
        cur_step = 5'd0;
        tone_live = 1'b0;
        started = run_pattern_step(load);
      end
      KIND_CLEAR: begin
        cur_level = LVL_NONE;
        tone_live = 1'b0;
      end
      KIND_EXPIRE: begin
        // tone check only when the step just ended was a tone
        if (tone_live) begin
          if (tone_heard) begin
            r.fail_clear = 1'b1;
            miss_count = 2'd0;
          end else if (miss_count >= miss_cap) begin
            r.fail_raise = 1'b1;
          end else begin
            miss_count = miss_count + 2'd1;
          end
        end
        started = run_pattern_step(load);
      end
      default: begin
        if (tone_live) tone_heard = 1'b1;
      end
    endcase
    r.tone_on = tone_live;
    r.tone_period = held_period;
    r.timer_load = started ? load : 8'h00;
    r.timer_running = started;
    r.step_index = cur_step;
    return r;
  endfunction

  // Input driver: one decision per edge, fed from stim_items
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) tone_results_due.push_back(predict_tone_result(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stim_items.size() > 0) begin
          in_data <= stim_items.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stalls after each transfer
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready) stall_left = pick_gap();
    end
  end

  // Result checker
  out_item_t due;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tone_results_due.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data);
        errors++;
      end else begin
        due = tone_results_due.pop_front();
        if (out_data !== due) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %p", due);
          $display("  actual   %p", out_data);
          errors++;
        end
      end
    end
  end

  task automatic push_item(input kind_t kind, input logic [1:0] lvl);
    in_item_t it;
    it.kind = kind;
    it.alarm_level = lvl;
    stim_items.push_back(it);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_reg(input logic [4:0] addr, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr[4:2])
      REG_DUR_LONG, REG_DUR_400, REG_DUR_200, REG_DUR_180, REG_DUR_100:
        dur_regs[addr[4:2]] = val[7:0];
      REG_MISS_LIMIT: miss_cap = val[1:0];
      default: ;
    endcase
  endtask

  // Write all registers; upper data bits carry junk that must be dropped
  task automatic write_all(input logic [7:0] d_long, input logic [7:0] d_400,
                           input logic [7:0] d_200, input logic [7:0] d_180,
                           input logic [7:0] d_100, input logic [1:0] ml);
    write_reg({REG_DUR_LONG, 2'b00}, {24'($urandom), d_long});
    write_reg({REG_DUR_400, 2'b00}, {24'($urandom), d_400});
    write_reg({REG_DUR_200, 2'b00}, {24'($urandom), d_200});
    write_reg({REG_DUR_180, 2'b00}, {24'($urandom), d_180});
    write_reg({REG_DUR_100, 2'b00}, {24'($urandom), d_100});
    write_reg({REG_MISS_LIMIT, 2'b00}, {30'($urandom), ml});
  endtask

  // Block until all items are sent and all results are in
  task automatic wait_drained();
    @(negedge clk);
    while (stim_items.size() != 0 || in_valid || tone_results_due.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Mostly well-formed alarm runs: a level set, then timer expiries with
  // heard reports at a per-run rate; the rest is random noise
  task automatic queue_random(input int count);
    int made;
    int n;
    int p_heard;
    in_item_t it;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 75) begin
        push_item(KIND_SET, ($urandom_range(0, 19) == 0) ? LVL_NONE :
                  2'($urandom_range(1, 3)));
        made++;
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 24);
        p_heard = $urandom_range(0, 4) * 25;
        repeat (n) begin
          push_item(KIND_EXPIRE, 2'($urandom_range(0, 3)));
          made++;
          if ($urandom_range(0, 99) < p_heard) begin
            push_item(KIND_HEARD, 2'($urandom_range(0, 3)));
            made++;
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          push_item(KIND_CLEAR, 2'($urandom_range(0, 3)));
          made++;
        end
      end else begin
        it = in_item_t'($urandom_range(0, 15));
        stim_items.push_back(it);
        made++;
      end
    end
  endtask

  // Run limit
  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence
  initial begin
    dur_regs[DUR_LONG] = 8'd255;
    dur_regs[DUR_400] = 8'd102;
    dur_regs[DUR_200] = 8'd51;
    dur_regs[DUR_180] = 8'd46;
    dur_regs[DUR_100] = 8'd26;
    miss_cap = 2'd2;
    cur_level = LVL_NONE;
    cur_step = 5'd0;
    tone_live = 1'b0;
    tone_heard = 1'b1;
    miss_count = 2'd0;
    held_period = NOTE_NONE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset register values
    push_item(KIND_EXPIRE, LVL_HIGH);   // no alarm: no timer
    push_item(KIND_HEARD, LVL_NONE);    // silent: ignored
    push_item(KIND_SET, LVL_LOW);
    push_item(KIND_HEARD, LVL_NONE);
    push_item(KIND_EXPIRE, LVL_NONE);   // heard: fail clear pulse
    push_item(KIND_HEARD, LVL_MED);     // during a gap: ignored
    push_item(KIND_EXPIRE, LVL_NONE);
    push_item(KIND_EXPIRE, LVL_NONE);   // missed
    push_item(KIND_SET, LVL_HIGH);      // set skips the tone check
    push_item(KIND_EXPIRE, LVL_NONE);   // missed
    push_item(KIND_EXPIRE, LVL_NONE);
    push_item(KIND_EXPIRE, LVL_NONE);   // missed at the limit: raise
    push_item(KIND_EXPIRE, LVL_NONE);
    push_item(KIND_HEARD, LVL_HIGH);
    push_item(KIND_EXPIRE, LVL_NONE);   // clear, 400 ms gap next
    push_item(KIND_SET, LVL_MED);
    push_item(KIND_CLEAR, LVL_MED);
    push_item(KIND_EXPIRE, LVL_LOW);    // cleared: no timer, step kept
    push_item(KIND_HEARD, LVL_NONE);
    push_item(KIND_SET, LVL_NONE);
    push_item(KIND_SET, LVL_HIGH);
    push_item(KIND_EXPIRE, LVL_NONE);
    push_item(KIND_CLEAR, LVL_HIGH);
    push_item(KIND_SET, LVL_LOW);
    push_item(KIND_SET, LVL_MED);
    queue_random(360);
    wait_drained();

    // Maximum durations, highest miss limit
    write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 2'd3);
    queue_random(360);
    wait_drained();

    // Zero durations, fail on the first miss; no idling in this phase
    write_all(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2'd0);
    write_reg(5'd24, $urandom);
    write_reg(5'd28, $urandom);
    idle_on = 1'b0;
    queue_random(360);
    wait_drained();
    idle_on = 1'b1;

    // Random settings
    write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              2'($urandom));
    queue_random(360);
    wait_drained();

    write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              2'd1);
    queue_random(360);
    wait_drained();

    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
